>>> hdl/dependency_cycle_finder_defines.svh
// Assertion macros for the dependency cycle finder checker.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef DEPENDENCY_CYCLE_FINDER_DEFINES_SVH
`define DEPENDENCY_CYCLE_FINDER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define DCF_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dependency_cycle_finder port check failed");

// Next-cycle implication, disabled during reset.
`define DCF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dependency_cycle_finder port check failed");

`endif

>>> hdl/dcf_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the dependency cycle finder.
// No dependencies; used by the controller, the datapath and the top level.
package dcf_pkg;

    localparam int MAX_NODES = 32;
    localparam int ID_W      = $clog2(MAX_NODES);
    localparam int CNT_W     = $clog2(MAX_NODES + 1);
    localparam int NC_W      = 6;
    localparam int ACT_W     = 3;
    localparam int IN_DATA_W = 16;
    localparam int OUT_DATA_W = 8;

    // Action codes carried in the input tuser.
    typedef enum logic [ACT_W-1:0] {
        ACT_ADD    = 3'd0,
        ACT_REMOVE = 3'd1,
        ACT_CLEAR  = 3'd2,
        ACT_CHECK  = 3'd3,
        ACT_WOULD  = 3'd4,
        ACT_ANY    = 3'd5
    } action_t;

    // Source of the next result transfer.
    typedef enum logic [1:0] {
        EMIT_STACK = 2'd0,
        EMIT_TOP   = 2'd1,
        EMIT_HIT   = 2'd2,
        EMIT_NONE  = 2'd3
    } emit_sel_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic      capture;
        logic      edit_rd;
        logic      edit_wr;
        logic      clr_graph;
        logic      start_from;
        logic      start_zero;
        logic      start_inc;
        logic      walk_init;
        logic      adv;
        logic      push;
        logic      pop;
        logic      pop_load;
        logic      hit;
        logic      rep_next;
        logic      emit;
        emit_sel_t emit_sel;
    } dcf_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        action_t act;
        logic    would_ok;
        logic    no_starts;
        logic    more_starts;
        logic    top_missing;
        logic    scan_end;
        logic    bit_set;
        logic    d_vis;
        logic    d_onp;
        logic    d_is_top;
        logic    len_one;
        logic    stack_full;
        logic    rep_match;
        logic    rep_done;
        logic    out_free;
    } dcf_sts_t;

endpackage

>>> hdl/dcf_controller.sv
`timescale 1ns / 1ps
// Sequencer for the dependency cycle finder: decodes actions and steps the walk.
// Depends on dcf_pkg for the command and status structs.
module dcf_controller import dcf_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  dcf_sts_t sts,
    output dcf_cmd_t cmd
);

    typedef enum logic [9:0] {
        ST_IDLE   = 10'b0000000001,
        ST_DECODE = 10'b0000000010,
        ST_EDIT   = 10'b0000000100,
        ST_START  = 10'b0000001000,
        ST_SCAN   = 10'b0000010000,
        ST_POP    = 10'b0000100000,
        ST_FIND   = 10'b0001000000,
        ST_TOP    = 10'b0010000000,
        ST_HIT    = 10'b0100000000,
        ST_NONE   = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;
    logic   emitting_reg, emitting_next;
    logic   find_show;

    assign in_ready  = (state_reg == ST_IDLE);
    assign find_show = emitting_reg || sts.rep_match;

    // Next-state and command decode.
    always_comb
    begin
        cmd           = '0;
        state_next    = state_reg;
        emitting_next = emitting_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                case (sts.act)
                    ACT_ADD, ACT_REMOVE:
                    begin
                        cmd.edit_rd = 1'b1;
                        state_next  = ST_EDIT;
                    end
                    ACT_CLEAR:
                    begin
                        cmd.clr_graph = 1'b1;
                        state_next    = ST_IDLE;
                    end
                    ACT_CHECK:
                    begin
                        cmd.start_from = 1'b1;
                        state_next     = ST_START;
                    end
                    ACT_WOULD:
                    begin
                        if (sts.would_ok)
                        begin
                            cmd.start_from = 1'b1;
                            state_next     = ST_START;
                        end
                        else
                        begin
                            state_next = ST_NONE;
                        end
                    end
                    ACT_ANY:
                    begin
                        if (sts.no_starts)
                        begin
                            state_next = ST_NONE;
                        end
                        else
                        begin
                            cmd.start_zero = 1'b1;
                            state_next     = ST_START;
                        end
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_EDIT:
            begin
                cmd.edit_wr = 1'b1;
                state_next  = ST_IDLE;
            end
            ST_START:
            begin
                cmd.walk_init = 1'b1;
                state_next    = ST_SCAN;
            end
            ST_SCAN:
            begin
                // One adjacency bit of the top node per cycle.
                if (sts.top_missing || sts.scan_end)
                begin
                    cmd.pop = 1'b1;
                    if (sts.len_one)
                    begin
                        if ((sts.act == ACT_ANY) && sts.more_starts)
                        begin
                            cmd.start_inc = 1'b1;
                            state_next    = ST_START;
                        end
                        else
                        begin
                            state_next = ST_NONE;
                        end
                    end
                    else
                    begin
                        state_next = ST_POP;
                    end
                end
                else if (!sts.bit_set)
                begin
                    cmd.adv = 1'b1;
                end
                else if (!sts.d_vis)
                begin
                    if (sts.stack_full)
                    begin
                        cmd.adv = 1'b1;
                    end
                    else
                    begin
                        cmd.push = 1'b1;
                    end
                end
                else if (sts.d_onp)
                begin
                    cmd.hit       = 1'b1;
                    emitting_next = 1'b0;
                    state_next    = sts.d_is_top ? ST_TOP : ST_FIND;
                end
                else
                begin
                    cmd.adv = 1'b1;
                end
            end
            ST_POP:
            begin
                cmd.pop_load = 1'b1;
                state_next   = ST_SCAN;
            end
            ST_FIND:
            begin
                // Walk the stored path from the bottom; report from the repeated node on.
                if (!find_show || sts.out_free)
                begin
                    if (find_show)
                    begin
                        cmd.emit      = 1'b1;
                        cmd.emit_sel  = EMIT_STACK;
                        emitting_next = 1'b1;
                    end
                    if (sts.rep_done)
                    begin
                        state_next = ST_TOP;
                    end
                    else
                    begin
                        cmd.rep_next = 1'b1;
                    end
                end
            end
            ST_TOP:
            begin
                if (sts.out_free)
                begin
                    cmd.emit     = 1'b1;
                    cmd.emit_sel = EMIT_TOP;
                    state_next   = ST_HIT;
                end
            end
            ST_HIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit     = 1'b1;
                    cmd.emit_sel = EMIT_HIT;
                    state_next   = ST_IDLE;
                end
            end
            ST_NONE:
            begin
                if (sts.out_free)
                begin
                    cmd.emit     = 1'b1;
                    cmd.emit_sel = EMIT_NONE;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            emitting_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            emitting_reg <= emitting_next;
        end
    end

endmodule

>>> hdl/dcf_datapath.sv
`timescale 1ns / 1ps
// Datapath of the dependency cycle finder: adjacency memory, path stack, marks and output register.
// Depends on dcf_pkg; driven by dcf_controller through the command struct.
module dcf_datapath import dcf_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [ACT_W-1:0]      in_action,
    input  logic [ID_W-1:0]       in_from,
    input  logic [ID_W-1:0]       in_to,
    input  logic                  cfg_we,
    input  logic [NC_W-1:0]       cfg_value,
    input  dcf_cmd_t              cmd,
    output dcf_sts_t              sts,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  out_found,
    output logic [ID_W-1:0]       out_id,
    output logic                  out_last
);

    // Adjacency memory with one valid bit per row; an invalid row reads as empty.
    logic [MAX_NODES-1:0] adj_mem [MAX_NODES];
    logic [MAX_NODES-1:0] row_vld_reg;
    logic [MAX_NODES-1:0] adj_q;
    logic                 adj_vld_q;
    logic                 ovl_q;

    // Path stack holds the parents below the top node with their resume positions.
    logic [ID_W-1:0]  stk_node_mem [MAX_NODES];
    logic [CNT_W-1:0] stk_pos_mem [MAX_NODES];
    logic [ID_W-1:0]  stk_node_q;
    logic [CNT_W-1:0] stk_pos_q;

    action_t              act_reg;
    logic [ID_W-1:0]      from_reg;
    logic [ID_W-1:0]      to_reg;
    logic [NC_W-1:0]      node_count_reg;
    logic [ID_W-1:0]      start_reg;
    logic [ID_W-1:0]      top_reg;
    logic [CNT_W-1:0]     pos_reg;
    logic [CNT_W-1:0]     len_reg;
    logic [MAX_NODES-1:0] vis_reg;
    logic [MAX_NODES-1:0] onp_reg;
    logic [ID_W-1:0]      hit_reg;
    logic [ID_W-1:0]      rep_reg;
    logic                 out_valid_reg;
    logic                 out_found_reg;
    logic [ID_W-1:0]      out_id_reg;
    logic                 out_last_reg;

    localparam logic [MAX_NODES-1:0] ONE_HOT0 = {{(MAX_NODES-1){1'b0}}, 1'b1};

    logic [CNT_W-1:0]     live;
    logic [MAX_NODES-1:0] row;
    logic [MAX_NODES-1:0] edit_row;
    logic [ID_W-1:0]      d;
    logic [CNT_W-1:0]     len_m1;
    logic [CNT_W-1:0]     len_m2;
    logic                 adj_rd_en;
    logic [ID_W-1:0]      adj_rd_addr;
    logic                 stk_rd_en;
    logic [ID_W-1:0]      stk_rd_addr;

    // Effective node count, capped at the matrix size.
    assign live = (CNT_W'(node_count_reg) > CNT_W'(MAX_NODES)) ? CNT_W'(MAX_NODES)
                                                                : CNT_W'(node_count_reg);

    // Current row, with the trial edge of a would-create query laid over it.
    assign row = (adj_vld_q ? adj_q : '0) | (ovl_q ? (ONE_HOT0 << to_reg) : '0);
    assign d      = pos_reg[ID_W-1:0];
    assign len_m1 = len_reg - CNT_W'(1);
    assign len_m2 = len_reg - CNT_W'(2);

    // Row after an add or remove.
    always_comb
    begin
        edit_row = adj_vld_q ? adj_q : '0;
        if (act_reg == ACT_ADD)
        begin
            edit_row = edit_row | (ONE_HOT0 << to_reg);
        end
        else
        begin
            edit_row = edit_row & ~(ONE_HOT0 << to_reg);
        end
    end

    // Adjacency read address selection.
    always_comb
    begin
        adj_rd_en   = cmd.edit_rd | cmd.walk_init | cmd.push | cmd.pop_load;
        adj_rd_addr = from_reg;
        if (cmd.walk_init)
        begin
            adj_rd_addr = start_reg;
        end
        else if (cmd.push)
        begin
            adj_rd_addr = d;
        end
        else if (cmd.pop_load)
        begin
            adj_rd_addr = stk_node_q;
        end
    end

    // Stack read address selection.
    always_comb
    begin
        stk_rd_en   = cmd.pop | cmd.hit | cmd.rep_next;
        stk_rd_addr = len_m2[ID_W-1:0];
        if (cmd.hit)
        begin
            stk_rd_addr = '0;
        end
        else if (cmd.rep_next)
        begin
            stk_rd_addr = rep_reg + ID_W'(1);
        end
    end

    // Adjacency memory write and registered read.
    always_ff @(posedge clk)
    begin
        if (cmd.edit_wr)
        begin
            adj_mem[from_reg] <= edit_row;
        end
        if (adj_rd_en)
        begin
            adj_q     <= adj_mem[adj_rd_addr];
            adj_vld_q <= row_vld_reg[adj_rd_addr];
            ovl_q     <= (act_reg == ACT_WOULD) && (adj_rd_addr == from_reg);
        end
    end

    // Row valid bits: cleared by reset and by a clear-graph action.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_vld_reg <= '0;
        end
        else if (cmd.clr_graph)
        begin
            row_vld_reg <= '0;
        end
        else if (cmd.edit_wr)
        begin
            row_vld_reg[from_reg] <= 1'b1;
        end
    end

    // Path stack write on push and registered read.
    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            stk_node_mem[len_m1[ID_W-1:0]] <= top_reg;
            stk_pos_mem[len_m1[ID_W-1:0]]  <= pos_reg + CNT_W'(1);
        end
        if (stk_rd_en)
        begin
            stk_node_q <= stk_node_mem[stk_rd_addr];
            stk_pos_q  <= stk_pos_mem[stk_rd_addr];
        end
    end

    // Captured action, start node, top of path and report index.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            act_reg  <= action_t'(in_action);
            from_reg <= in_from;
            to_reg   <= in_to;
        end
        if (cmd.start_from)
        begin
            start_reg <= from_reg;
        end
        else if (cmd.start_zero)
        begin
            start_reg <= '0;
        end
        else if (cmd.start_inc)
        begin
            start_reg <= start_reg + ID_W'(1);
        end
        if (cmd.walk_init)
        begin
            top_reg <= start_reg;
            pos_reg <= '0;
        end
        else if (cmd.push)
        begin
            top_reg <= d;
            pos_reg <= '0;
        end
        else if (cmd.pop_load)
        begin
            top_reg <= stk_node_q;
            pos_reg <= stk_pos_q;
        end
        else if (cmd.adv)
        begin
            pos_reg <= pos_reg + CNT_W'(1);
        end
        if (cmd.hit)
        begin
            hit_reg <= d;
            rep_reg <= '0;
        end
        else if (cmd.rep_next)
        begin
            rep_reg <= rep_reg + ID_W'(1);
        end
    end

    // Path length and marks.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
            vis_reg <= '0;
            onp_reg <= '0;
        end
        else if (cmd.walk_init)
        begin
            len_reg <= CNT_W'(1);
            vis_reg <= ONE_HOT0 << start_reg;
            onp_reg <= ONE_HOT0 << start_reg;
        end
        else if (cmd.push)
        begin
            len_reg <= len_reg + CNT_W'(1);
            vis_reg <= vis_reg | (ONE_HOT0 << d);
            onp_reg <= onp_reg | (ONE_HOT0 << d);
        end
        else if (cmd.pop)
        begin
            len_reg <= len_m1;
            onp_reg <= onp_reg & ~(ONE_HOT0 << top_reg);
        end
    end

    // Node count register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= NC_W'(MAX_NODES);
        end
        else if (cfg_we)
        begin
            node_count_reg <= cfg_value;
        end
    end

    // Output register: loaded on a result, freed by the downstream transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            case (cmd.emit_sel)
                EMIT_STACK:
                begin
                    out_found_reg <= 1'b1;
                    out_id_reg    <= stk_node_q;
                    out_last_reg  <= 1'b0;
                end
                EMIT_TOP:
                begin
                    out_found_reg <= 1'b1;
                    out_id_reg    <= top_reg;
                    out_last_reg  <= 1'b0;
                end
                EMIT_HIT:
                begin
                    out_found_reg <= 1'b1;
                    out_id_reg    <= hit_reg;
                    out_last_reg  <= 1'b1;
                end
                default:
                begin
                    out_found_reg <= 1'b0;
                    out_id_reg    <= '0;
                    out_last_reg  <= 1'b1;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_found = out_found_reg;
    assign out_id    = out_id_reg;
    assign out_last  = out_last_reg;

    // Status toward the controller.
    always_comb
    begin
        sts.act         = act_reg;
        sts.would_ok    = (CNT_W'(from_reg) < live) && (CNT_W'(to_reg) < live);
        sts.no_starts   = (live == '0);
        sts.more_starts = (CNT_W'(start_reg) + CNT_W'(1)) < live;
        sts.top_missing = CNT_W'(top_reg) >= live;
        sts.scan_end    = (pos_reg == CNT_W'(MAX_NODES));
        sts.bit_set     = row[d];
        sts.d_vis       = vis_reg[d];
        sts.d_onp       = onp_reg[d];
        sts.d_is_top    = (d == top_reg);
        sts.len_one     = (len_reg == CNT_W'(1));
        sts.stack_full  = (len_reg == CNT_W'(MAX_NODES));
        sts.rep_match   = (stk_node_q == hit_reg);
        sts.rep_done    = (CNT_W'(rep_reg) + CNT_W'(2)) == len_reg;
        sts.out_free    = !out_valid_reg || out_ready;
    end

endmodule

>>> hdl/dependency_cycle_finder.sv
`timescale 1ns / 1ps
// Top level of the dependency cycle finder: stream ports, controller and datapath.
// Depends on dcf_pkg, dcf_controller and dcf_datapath.
//
//   Channel   Direction  Handshake             Payload
//   s_axis    in         tvalid / tready       tuser action, tdata from_node and to_node
//   m_axis    out        tvalid / tready       tuser cycle_found, tdata node_id, tlast last
//   cfg       in         cfg_valid / cfg_ready cfg_data node_count
//
// Edits read the row when decoded and write it back in the edit state; clear graph resets the per-row valid bits.
// In a walk the scan loop tests one adjacency bit per cycle, and each pop passes through a
// state that reloads the parent's row and resume position; check any repeats
// the walk once per start. A cycle report first searches the stack for the repeated node,
// one entry per cycle, then gives one result per cycle unless m_axis stalls.
// Reset clears the graph, the marks and the node count (back to 32) at once.
// A new item is taken only once the previous one is done; its last result may still wait.
module dependency_cycle_finder import dcf_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [4:0] from_node, [9:5] to_node, rest zero
    input  logic [ACT_W-1:0]      s_axis_tuser,   // [2:0] action
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [4:0] node_id, rest zero
    output logic                  m_axis_tuser,   // [0] cycle_found
    output logic                  m_axis_tlast,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [NC_W-1:0]       cfg_data
);

    dcf_cmd_t        cmd;
    dcf_sts_t        sts;
    logic [ID_W-1:0] out_id;

    // The register write is always taken.
    assign cfg_ready = 1'b1;

    dcf_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    dcf_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_action (s_axis_tuser),
        .in_from   (s_axis_tdata[ID_W-1:0]),
        .in_to     (s_axis_tdata[2*ID_W-1:ID_W]),
        .cfg_we    (cfg_valid & cfg_ready),
        .cfg_value (cfg_data),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_found (m_axis_tuser),
        .out_id    (out_id),
        .out_last  (m_axis_tlast)
    );

    // Result node id, padded to a whole byte.
    assign m_axis_tdata = {{(OUT_DATA_W-ID_W){1'b0}}, out_id};

endmodule

>>> hdl/dcf_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the dependency cycle finder, bound to the top level.
// Depends on dcf_pkg and dependency_cycle_finder_defines.svh.
`include "dependency_cycle_finder_defines.svh"

module dcf_checker import dcf_pkg::*; (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic [IN_DATA_W-1:0]  s_axis_tdata,
    input logic [ACT_W-1:0]      s_axis_tuser,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata,
    input logic                  m_axis_tuser,
    input logic                  m_axis_tlast,
    input logic                  cfg_valid,
    input logic                  cfg_ready,
    input logic [NC_W-1:0]       cfg_data
);

    // A stalled result holds its payload.
    `DCF_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))

    // A no-cycle answer is a single last result with node id zero.
    `DCF_ASSERT_NOW(a_none_form, m_axis_tvalid && !m_axis_tuser, m_axis_tlast && (m_axis_tdata == '0))

    // No new item is taken while a cycle report is still being sent.
    `DCF_ASSERT_NOW(a_busy_report, m_axis_tvalid && !m_axis_tlast, !s_axis_tready)

    // An accepted item keeps the input closed for the next cycle.
    `DCF_ASSERT_NEXT(a_one_item, s_axis_tvalid && s_axis_tready, !s_axis_tready)

endmodule

bind dependency_cycle_finder dcf_checker u_dcf_checker (.*);
